FILE: hw/rtl/dbp_pkg.sv
// Shared types and constants for the depth-to-point back-projection block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

	// Field widths
	localparam int DepthW = 16;
	localparam int CoordW = 20;
	localparam int InvW   = 24;
	localparam int CtrW   = 16;
	localparam int SizeW  = 13;
	localparam int PosW   = 12;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;
	localparam int InDataW  = 16;
	localparam int OutDataW = 56;

	// Fixed-point scaling: product carries this many extra fraction bits
	localparam int RoundBits = 28;

	// Register reset values
	localparam logic [InvW-1:0]   InvFocalXRst = 24'd32433;
	localparam logic [InvW-1:0]   InvFocalYRst = 24'd32485;
	localparam logic [CtrW-1:0]   CenterXRst   = 16'd5098;
	localparam logic [CtrW-1:0]   CenterYRst   = 16'd4085;
	localparam logic [DepthW-1:0] DepthMinRst  = 16'd164;
	localparam logic [DepthW-1:0] DepthMaxRst  = 16'd36864;
	localparam logic [SizeW-1:0]  ImageColsRst = 13'd640;
	localparam logic [SizeW-1:0]  ImageRowsRst = 13'd480;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_INV_FOCAL_X = 3'd0,
		REG_INV_FOCAL_Y = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_DEPTH_MIN   = 3'd4,
		REG_DEPTH_MAX   = 3'd5,
		REG_IMAGE_COLS  = 3'd6,
		REG_IMAGE_ROWS  = 3'd7
	} cfg_reg_t;

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL1 = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;  // input beat taken: latch operands, advance counters
		logic mul1;    // offset magnitude times depth
		logic mul2;    // times reciprocal focal length
		logic fin;     // round, saturate, load output register
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_window;  // current input depth lies strictly inside the window
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/depth_to_point_backprojection.sv
// Top level of the depth-to-point back-projection block: joins the
// controller and the datapath. Depends on dbp_pkg, dbp_ctrl, dbp_datapath.
//
// Takes one depth beat per pixel, scanned column-major (row fastest), and
// emits one 3-D point per sample strictly inside the depth window. A sample
// outside the window is taken and yields nothing. A sample inside passes
// through accept, two multiply steps, then round and saturate, before the
// next beat is taken. The two multiply steps chain offset, depth and
// reciprocal focal length. The result sits in an output register, so a new
// sample is accepted while a point still waits to be taken. If the previous
// point is still waiting when the next one is ready, the round step holds
// until that point is taken. Write the configuration only while the block
// is idle.
`timescale 1ns / 1ps
`default_nettype none

module depth_to_point_backprojection (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dbp_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [dbp_pkg::CfgDataW-1:0]      cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [dbp_pkg::InDataW-1:0]       s_tdata,   // [15:0] depth_sample
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [dbp_pkg::OutDataW-1:0]           m_tdata    // [19:0] point_x,
	                                                          // [39:20] point_y,
	                                                          // [55:40] point_z
);

	dbp_pkg::dp_cmd_t    cmd;
	dbp_pkg::dp_status_t status;
	logic signed [dbp_pkg::CoordW-1:0] point_x, point_y;
	logic [dbp_pkg::DepthW-1:0]        point_z;

	dbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dbp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.depth_sample (s_tdata[dbp_pkg::DepthW-1:0]),
		.cmd          (cmd),
		.status       (status),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z)
	);

	// Pack the point, first field lowest
	assign m_tdata = {point_z, point_y, point_x};

endmodule

`default_nettype wire

FILE: hw/rtl/dbp_ctrl.sv
// Controller for the back-projection block: sequences one sample through
// the multiply steps and owns the handshakes. Depends on dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	input  wire dbp_pkg::dp_status_t status,
	output dbp_pkg::dp_cmd_t        cmd
);

	dbp_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic fin_go;

	// Accept only between samples; the output register decouples the far side
	assign s_tready = (state_q == dbp_pkg::ST_IDLE);
	assign fin_go   = (state_q == dbp_pkg::ST_FIN) && (!out_valid_q || m_tready);

	always_comb begin
		cmd.accept = s_tvalid && s_tready;
		cmd.mul1   = (state_q == dbp_pkg::ST_MUL1);
		cmd.mul2   = (state_q == dbp_pkg::ST_MUL2);
		cmd.fin    = fin_go;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbp_pkg::ST_IDLE: begin
				if (s_tvalid && status.in_window)
					state_d = dbp_pkg::ST_MUL1;
			end
			dbp_pkg::ST_MUL1: state_d = dbp_pkg::ST_MUL2;
			dbp_pkg::ST_MUL2: state_d = dbp_pkg::ST_FIN;
			dbp_pkg::ST_FIN: begin
				if (fin_go)
					state_d = dbp_pkg::ST_IDLE;
			end
			default: state_d = dbp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dbp_datapath.sv
// Datapath for the back-projection block: configuration registers, pixel
// counters, multiply steps, rounding and saturation. Depends on dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbp_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dbp_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [dbp_pkg::CfgDataW-1:0]      cfg_data,
	input  wire logic [dbp_pkg::DepthW-1:0]        depth_sample,
	input  wire dbp_pkg::dp_cmd_t                  cmd,
	output dbp_pkg::dp_status_t                    status,
	output logic signed [dbp_pkg::CoordW-1:0]      point_x,
	output logic signed [dbp_pkg::CoordW-1:0]      point_y,
	output logic [dbp_pkg::DepthW-1:0]             point_z
);

	localparam int MagW  = dbp_pkg::CtrW;
	localparam int Prod1W = MagW + dbp_pkg::DepthW;
	localparam int Prod2W = Prod1W + dbp_pkg::InvW;

	logic [dbp_pkg::InvW-1:0]   inv_focal_x_q, inv_focal_y_q;
	logic [dbp_pkg::CtrW-1:0]   center_x_q, center_y_q;
	logic [dbp_pkg::DepthW-1:0] depth_min_q, depth_max_q;
	logic [dbp_pkg::SizeW-1:0]  image_cols_q, image_rows_q;
	logic [dbp_pkg::PosW-1:0]   col_q, row_q;

	logic [dbp_pkg::SizeW-1:0]  col_next, row_next;
	logic                       col_wrap, row_wrap;
	logic [MagW-1:0]            col16, row16;
	logic                       neg_x, neg_y;

	logic                       neg_x_s1, neg_y_s1;
	logic [MagW-1:0]            mag_x_s1, mag_y_s1;
	logic [dbp_pkg::DepthW-1:0] depth_s1;
	logic [Prod1W-1:0]          prod_x_s2, prod_y_s2;
	logic [Prod2W-1:0]          prod_x_s3, prod_y_s3;

	logic signed [dbp_pkg::CoordW-1:0] x_q, y_q;
	logic [dbp_pkg::DepthW-1:0]        z_q;

	// Round to nearest, ties away from zero, then clamp to the coordinate range
	function automatic logic [dbp_pkg::CoordW-1:0] round_sat(
		input logic              neg,
		input logic [Prod2W-1:0] prod
	);
		logic [Prod2W:0]                        sum;
		logic [Prod2W-dbp_pkg::RoundBits:0]     r;
		logic [dbp_pkg::CoordW-1:0]             res;
		sum = {1'b0, prod} + ((Prod2W+1)'(1) << (dbp_pkg::RoundBits - 1));
		r   = sum[Prod2W:dbp_pkg::RoundBits];
		if (neg) begin
			if (r > (Prod2W-dbp_pkg::RoundBits+1)'(1 << (dbp_pkg::CoordW - 1)))
				res = {1'b1, {(dbp_pkg::CoordW-1){1'b0}}};
			else
				res = (~r[dbp_pkg::CoordW-1:0]) + dbp_pkg::CoordW'(1);
		end else begin
			if (r > (Prod2W-dbp_pkg::RoundBits+1)'((1 << (dbp_pkg::CoordW - 1)) - 1))
				res = {1'b0, {(dbp_pkg::CoordW-1){1'b1}}};
			else
				res = r[dbp_pkg::CoordW-1:0];
		end
		return res;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q <= dbp_pkg::InvFocalXRst;
			inv_focal_y_q <= dbp_pkg::InvFocalYRst;
			center_x_q    <= dbp_pkg::CenterXRst;
			center_y_q    <= dbp_pkg::CenterYRst;
			depth_min_q   <= dbp_pkg::DepthMinRst;
			depth_max_q   <= dbp_pkg::DepthMaxRst;
			image_cols_q  <= dbp_pkg::ImageColsRst;
			image_rows_q  <= dbp_pkg::ImageRowsRst;
		end else if (cfg_we) begin
			case (dbp_pkg::cfg_reg_t'(cfg_index))
				dbp_pkg::REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data;
				dbp_pkg::REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data;
				dbp_pkg::REG_CENTER_X:    center_x_q <= cfg_data[dbp_pkg::CtrW-1:0];
				dbp_pkg::REG_CENTER_Y:    center_y_q <= cfg_data[dbp_pkg::CtrW-1:0];
				dbp_pkg::REG_DEPTH_MIN:   depth_min_q <= cfg_data[dbp_pkg::DepthW-1:0];
				dbp_pkg::REG_DEPTH_MAX:   depth_max_q <= cfg_data[dbp_pkg::DepthW-1:0];
				dbp_pkg::REG_IMAGE_COLS:  image_cols_q <= cfg_data[dbp_pkg::SizeW-1:0];
				dbp_pkg::REG_IMAGE_ROWS:  image_rows_q <= cfg_data[dbp_pkg::SizeW-1:0];
				default: ;
			endcase
		end
	end

	assign status.in_window = (depth_sample > depth_min_q) && (depth_sample < depth_max_q);

	// Pixel position advance: row fastest, wrap at size or at the counter limit
	assign row_next = {1'b0, row_q} + dbp_pkg::SizeW'(1);
	assign col_next = {1'b0, col_q} + dbp_pkg::SizeW'(1);
	assign row_wrap = (row_next >= image_rows_q) || row_next[dbp_pkg::SizeW-1];
	assign col_wrap = (col_next >= image_cols_q) || col_next[dbp_pkg::SizeW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.accept) begin
			if (row_wrap) begin
				row_q <= '0;
				col_q <= col_wrap ? '0 : col_next[dbp_pkg::PosW-1:0];
			end else begin
				row_q <= row_next[dbp_pkg::PosW-1:0];
			end
		end
	end

	// Signed pixel offset from the principal point, as sign and magnitude
	assign col16 = {col_q, 4'b0000};
	assign row16 = {row_q, 4'b0000};
	assign neg_x = col16 < center_x_q;
	assign neg_y = row16 < center_y_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			neg_x_s1 <= neg_x;
			neg_y_s1 <= neg_y;
			mag_x_s1 <= neg_x ? (center_x_q - col16) : (col16 - center_x_q);
			mag_y_s1 <= neg_y ? (center_y_q - row16) : (row16 - center_y_q);
			depth_s1 <= depth_sample;
		end
	end

	// Offset times depth
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod_x_s2 <= Prod1W'(mag_x_s1) * Prod1W'(depth_s1);
			prod_y_s2 <= Prod1W'(mag_y_s1) * Prod1W'(depth_s1);
		end
	end

	// Times reciprocal focal length
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			prod_x_s3 <= Prod2W'(prod_x_s2) * Prod2W'(inv_focal_x_q);
			prod_y_s3 <= Prod2W'(prod_y_s2) * Prod2W'(inv_focal_y_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			x_q <= round_sat(neg_x_s1, prod_x_s3);
			y_q <= round_sat(neg_y_s1, prod_y_s3);
			z_q <= depth_s1;
		end
	end

	assign point_x = x_q;
	assign point_y = y_q;
	assign point_z = z_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dbp_checker.sv
// Port-level checks for the back-projection block, attached by bind.
// Depends on depth_to_point_backprojection and dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [dbp_pkg::InDataW-1:0]   s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [dbp_pkg::OutDataW-1:0]  m_tdata
);

	// Stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// Stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// A new point appears only after the block stopped taking samples
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("point produced without compute cycles");

	// A point's depth lies above a lower bound, so it is never zero
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:40] != 16'd0))
		else $error("point with zero depth");

endmodule

bind depth_to_point_backprojection dbp_checker u_dbp_checker (.*);

`default_nettype wire
